>>> rtl/rmth_pkg.sv
// ============================================================================
// rmth_pkg
// Shared constants and types for the running median core: store sizes,
// cell link record, chain operation codes and controller states.
// ============================================================================
`default_nettype none

package rmth_pkg;

  localparam int CAPACITY = 1024;
  localparam int DEPTH    = (CAPACITY + 1) / 2;     // cells per half
  localparam int CNT_W    = $clog2(DEPTH + 1);      // per-half fill count
  localparam int SAMPLE_W = 32;
  localparam int MED_W    = 33;
  localparam int COUNT_W  = 11;
  localparam int TDATA_W  = 48;

  // what a chain does with the broadcast value this cycle
  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,    // sorted insert, chain grows by one
    OP_REPLACE    // drop head, sorted insert, size unchanged
  } op_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                       keep;   // holds a value >= broadcast value
    logic                       valid;
    logic signed [SAMPLE_W-1:0] val;
  } link_t;

  typedef enum logic {
    ST_IDLE,
    ST_MEDIAN
  } state_t;

endpackage

`default_nettype wire

>>> rtl/rmth_cell.sv
// ============================================================================
// rmth_cell
// One slot of a sorted chain (largest at the head). Compares its value with
// the broadcast word and takes its own, its neighbor's or the new value.
// ============================================================================
`default_nettype none

module rmth_cell (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire rmth_pkg::op_t                       op,
  input  wire logic signed [rmth_pkg::SAMPLE_W-1:0] x,
  input  wire rmth_pkg::link_t                     prev_link,  // toward head
  input  wire rmth_pkg::link_t                     next_link,  // toward tail
  output rmth_pkg::link_t                          link
);
  import rmth_pkg::*;

  logic signed [SAMPLE_W-1:0] val_r, val_nxt;
  logic                       valid_r, valid_nxt;
  logic                       keep;

  assign keep = valid_r && (val_r >= x);
  assign link = '{keep: keep, valid: valid_r, val: val_r};

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    case (op)
      OP_INSERT: begin
        // larger values stay, the rest move one slot toward the tail
        val_nxt   = keep ? val_r : (prev_link.keep ? x : prev_link.val);
        valid_nxt = valid_r | prev_link.valid;
      end
      OP_REPLACE: begin
        // everything moves one slot toward the head, then x drops in
        val_nxt = next_link.keep ? next_link.val : (keep ? x : val_r);
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/rmth_chain.sv
// ============================================================================
// rmth_chain
// Row of sorting cells holding one half of the samples, largest at the head.
// One insert or head replacement per cycle by broadcast compare and shift.
// ============================================================================
`default_nettype none

module rmth_chain (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire rmth_pkg::op_t                       op,
  input  wire logic signed [rmth_pkg::SAMPLE_W-1:0] x,
  output logic signed [rmth_pkg::SAMPLE_W-1:0]     head
);
  import rmth_pkg::*;

  link_t links [DEPTH];
  link_t head_link;
  link_t tail_link;

  // ahead of the head everything is kept; past the tail nothing is
  assign head_link = '{keep: 1'b1, valid: 1'b1, val: x};
  assign tail_link = '{keep: 1'b0, valid: 1'b0, val: x};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    link_t prev_l;
    link_t next_l;
    if (i == 0) begin : g_first
      assign prev_l = head_link;
    end else begin : g_mid_p
      assign prev_l = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_l = tail_link;
    end else begin : g_mid_n
      assign next_l = links[i+1];
    end
    rmth_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .x         (x),
      .prev_link (prev_l),
      .next_link (next_l),
      .link      (links[i])
    );
  end

  assign head = links[0].val;

endmodule

`default_nettype wire

>>> rtl/running_median_two_heaps_core.sv
// ============================================================================
// running_median_two_heaps_core
// Running median of a signed 32-bit sample stream, kept as two sorted halves.
// ============================================================================
// Usage:
//   in_*  : one sample word per handshake (in_tdata = sample).
//   out_* : one result word per sample: out_tdata = median_x2 (twice the
//           median, one fractional bit) and count; out_tuser = refused.
//   Each half lives in a row of 512 sorting cells, largest value at the head
//   (the upper half is stored bit-inverted so both rows sort the same way).
//   An accepted sample updates one or both rows; then, in ST_MEDIAN, the
//   head values are added (or one head is doubled) into the median and the
//   output register is loaded, once it no longer holds a stalled result.
//   in_tready is low in ST_MEDIAN, so the next sample is not taken before
//   the head-add step has updated the median that it is compared to.
//   Once 1024 samples are held, further samples are refused (out_tuser = 1)
//   and the median and count repeat.
//   Reset (rst_n low, synchronous) empties both rows and zeroes the median.
//   If out_tready is low, the result waits in the output register; one more
//   sample may be taken meanwhile and its result waits in the median stage.
// ============================================================================
`default_nettype none

module running_median_two_heaps_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [31:0]                   in_tdata,   // [31:0] sample
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [rmth_pkg::TDATA_W-1:0]       out_tdata,  // [32:0] median_x2, [43:33] count
  output logic                               out_tuser   // [0] refused
);
  import rmth_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]           lc_r, lc_nxt;
  logic [CNT_W-1:0]           uc_r, uc_nxt;
  logic [CNT_W:0]             held;
  logic signed [MED_W-1:0]    median_r, median_nxt;
  logic                       refused_r, refused_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [MED_W-1:0]    out_median_r;
  logic [COUNT_W-1:0]         out_count_r;
  logic                       out_refused_r;
  logic                       out_load;

  logic                       accept;
  logic                       full;
  logic signed [SAMPLE_W-1:0] s;
  logic signed [MED_W-1:0]    s_x2;
  logic                       gt;

  op_t                        lo_op, up_op;
  logic signed [SAMPLE_W-1:0] lo_x, up_x;
  logic signed [SAMPLE_W-1:0] lo_head, up_head_raw, up_head;
  logic signed [MED_W-1:0]    lo_ext, up_ext, med_calc;

  rmth_chain u_lower (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (lo_op),
    .x     (lo_x),
    .head  (lo_head)
  );

  rmth_chain u_upper (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (up_op),
    .x     (up_x),
    .head  (up_head_raw)
  );

  assign up_head = ~up_head_raw;

  assign accept = in_tvalid && in_tready;
  assign held   = {1'b0, lc_r} + {1'b0, uc_r};
  assign full   = (held == (CNT_W+1)'(CAPACITY));
  assign s      = signed'(in_tdata[SAMPLE_W-1:0]);
  assign s_x2   = {s, 1'b0};
  assign gt     = s_x2 > median_r;

  // route the sample (and possibly one top) into the halves
  always_comb begin
    lo_op       = OP_NONE;
    up_op       = OP_NONE;
    lo_x        = s;
    up_x        = ~s;
    lc_nxt      = lc_r;
    uc_nxt      = uc_r;
    refused_nxt = refused_r;
    if (accept) begin
      refused_nxt = full;
      if (!full) begin
        if (lc_r == uc_r) begin
          if (gt) begin
            up_op  = OP_INSERT;
            uc_nxt = uc_r + 1'b1;
          end else begin
            lo_op  = OP_INSERT;
            lc_nxt = lc_r + 1'b1;
          end
        end else if (lc_r > uc_r) begin
          up_op  = OP_INSERT;
          uc_nxt = uc_r + 1'b1;
          if (!gt) begin
            // lower top crosses over, sample takes its place
            lo_op = OP_REPLACE;
            up_x  = ~lo_head;
          end
        end else begin
          lo_op  = OP_INSERT;
          lc_nxt = lc_r + 1'b1;
          if (gt) begin
            up_op = OP_REPLACE;
            lo_x  = up_head;
          end
        end
      end
    end
  end

  // median from the two heads
  assign lo_ext = {lo_head[SAMPLE_W-1], lo_head};
  assign up_ext = {up_head[SAMPLE_W-1], up_head};

  always_comb begin
    if (lc_r == uc_r) begin
      med_calc = lo_ext + up_ext;
    end else if (lc_r > uc_r) begin
      med_calc = {lo_head, 1'b0};
    end else begin
      med_calc = {up_head, 1'b0};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    out_load      = 1'b0;
    median_nxt    = median_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_MEDIAN;
        end
      end
      ST_MEDIAN: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          median_nxt    = med_calc;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lc_r        <= '0;
      uc_r        <= '0;
      median_r    <= '0;
      refused_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lc_r        <= lc_nxt;
      uc_r        <= uc_nxt;
      median_r    <= median_nxt;
      refused_r   <= refused_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_median_r  <= med_calc;
      out_count_r   <= COUNT_W'(held);
      out_refused_r <= refused_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(TDATA_W-MED_W-COUNT_W)'(0), out_count_r, out_median_r};
  assign out_tuser  = out_refused_r;

endmodule

`default_nettype wire

>>> rtl/rmth_checker.sv
// ============================================================================
// rmth_checker
// Port-level checks for the running median core, bound to the top level.
// ============================================================================
`default_nettype none

module rmth_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [rmth_pkg::TDATA_W-1:0]  out_tdata,
  input wire logic                          out_tuser
);
  import rmth_pkg::*;

  logic [COUNT_W-1:0] cnt;
  assign cnt = out_tdata[MED_W+COUNT_W-1:MED_W];

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt <= COUNT_W'(CAPACITY))
    else $error("count above capacity");

  a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> cnt == COUNT_W'(CAPACITY))
    else $error("refused while not full");

  // samples are never taken back to back
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("samples taken back to back");

endmodule

bind running_median_two_heaps_core rmth_checker u_rmth_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
